@@ rtl/depth_sigma_window_fusion_unit_macros.svh @@
// Assertion macros shared by the depth sigma window fusion RTL.
`ifndef DEPTH_SIGMA_WINDOW_FUSION_UNIT_MACROS_SVH
`define DEPTH_SIGMA_WINDOW_FUSION_UNIT_MACROS_SVH
// Condition that must hold at every clock edge outside reset.
`define DSWF_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Implication checked in the same cycle.
`define DSWF_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

@@ rtl/dswf_pkg.sv @@
// Package with types, constants and helpers of the depth sigma window fusion unit.
`default_nettype none
package dswf_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int HW            = 11;
    localparam int QDEPTH        = 2;

    localparam logic [21:0] DQ_MAX      = 22'h3FFFFF;
    localparam logic [31:0] SIGMA_MAX   = 32'hFFFFFFFF;
    localparam logic [29:0] RECIP_125   = 30'd549755814;
    localparam logic [31:0] MM_ROUND    = 32'd500;

    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd451;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd361;
    localparam logic [31:0] RST_COEF_SQUARE  = 32'd26142;
    localparam logic [31:0] RST_COEF_LINEAR  = 32'hFFFF_12BF;
    localparam logic [31:0] RST_COEF_CONST   = 32'd75970;
    localparam logic [15:0] RST_MIN_DEPTH    = 16'd500;
    localparam logic [31:0] RST_SIGMA_FLOOR  = 32'd168;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam int S2_W  = 69;
    localparam int S1_W  = 35;
    localparam int NUM_W = 74;
    localparam int DEN_W = 9;

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_COEF_SQUARE  = 3'd2,
        CFG_COEF_LINEAR  = 3'd3,
        CFG_COEF_CONST   = 3'd4,
        CFG_MIN_DEPTH    = 3'd5,
        CFG_SIGMA_FLOOR  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic        [10:0] frame_width;
        logic        [10:0] frame_height;
        logic signed [31:0] coef_square;
        logic signed [31:0] coef_linear;
        logic signed [31:0] coef_const;
        logic        [15:0] min_depth_mm;
        logic        [31:0] sigma_floor;
    } cfg_t;

    typedef struct packed {
        logic [15:0] mm;
        logic [21:0] dq;
        logic [31:0] sigma;
    } pix_t;

    localparam int PIX_W = $bits(pix_t);

    typedef struct packed {
        logic flush;
        pix_t pix;
    } qitem_t;

    typedef enum logic [2:0] {
        FR_IDLE, FR_DIV, FR_CLAMP, FR_SQ, FR_POLY, FR_SUM, FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE, B_READ, B_APPLY, B_FSTART, B_FUSE, B_OUT
    } back_state_t;

    typedef enum logic [3:0] {
        FU_IDLE, FU_MUL, FU_ACC, FU_SQ_LO, FU_SQ_HI, FU_SUB, FU_DIV, FU_CHECK,
        FU_ROOT, FU_DONE
    } fuse_state_t;

    function automatic logic [1:0] win_shift(input logic [3:0] k);
        logic [1:0] sh;
        unique case (k) inside
            4'd4:                         sh = 2'd2;
            4'd1, 4'd3, 4'd5, 4'd7:       sh = 2'd1;
            default:                      sh = 2'd0;
        endcase
        return sh;
    endfunction

endpackage
`default_nettype wire

@@ rtl/dswf_ram.sv @@
// Generic single write port RAM with registered read.
`default_nettype none
module dswf_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/dswf_front.sv @@
// Front end: accepts items, converts depth to metres and predicts sigma.
`default_nettype none
module dswf_front
    import dswf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        in_action,
    input  wire logic [15:0] in_depth_mm,
    output logic             q_valid,
    input  wire logic        q_ready,
    output qitem_t           q_data
);
    front_state_t       state_reg, state_next;
    logic               flush_reg, flush_next;
    logic [15:0]        mm_reg, mm_next;
    logic [28:0]        x_reg, x_next;
    logic [58:0]        prod_reg, prod_next;
    logic [21:0]        dq_reg, dq_next;
    logic [27:0]        dsq_reg, dsq_next;
    logic signed [60:0] t1_reg, t1_next;
    logic signed [54:0] t2_reg, t2_next;
    logic [31:0]        pred_reg, pred_next;
    logic [31:0]        scaled;
    logic [22:0]        quo;
    logic [43:0]        sq;
    logic signed [63:0] acc;
    logic [47:0]        rounded;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flush_reg <= flush_next;
        mm_reg    <= mm_next;
        x_reg     <= x_next;
        prod_reg  <= prod_next;
        dq_reg    <= dq_next;
        dsq_reg   <= dsq_next;
        t1_reg    <= t1_next;
        t2_reg    <= t2_next;
        pred_reg  <= pred_next;
    end

    always_comb
    begin
        state_next = state_reg;
        flush_next = flush_reg;
        mm_next    = mm_reg;
        x_next     = x_reg;
        prod_next  = prod_reg;
        dq_next    = dq_reg;
        dsq_next   = dsq_reg;
        t1_next    = t1_reg;
        t2_next    = t2_reg;
        pred_next  = pred_reg;
        in_ready   = 1'b0;
        q_valid    = 1'b0;
        scaled     = {in_depth_mm, 16'b0} + MM_ROUND;
        quo        = prod_reg[58:36];
        sq         = 44'(dq_reg) * 44'(dq_reg) + 44'd32768;
        acc        = 64'(t1_reg) + 64'(t2_reg) + (64'($signed(cfg.coef_const)) <<< 16);
        rounded    = 48'(64'(acc + 64'sd32768) >> 16);
        unique case (state_reg)
            FR_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    flush_next = (in_action == ACT_FLUSH);
                    mm_next    = in_depth_mm;
                    x_next     = scaled[31:3];
                    dq_next    = '0;
                    pred_next  = '0;
                    state_next = (in_action == ACT_FLUSH) ? FR_PUSH : FR_DIV;
                end
            end
            FR_DIV:
            begin
                prod_next  = 59'(x_reg) * 59'(RECIP_125);
                state_next = FR_CLAMP;
            end
            FR_CLAMP:
            begin
                dq_next    = (quo > {1'b0, DQ_MAX}) ? DQ_MAX : quo[21:0];
                state_next = FR_SQ;
            end
            FR_SQ:
            begin
                dsq_next   = sq[43:16];
                state_next = FR_POLY;
            end
            FR_POLY:
            begin
                t1_next    = $signed(cfg.coef_square) * $signed({1'b0, dsq_reg});
                t2_next    = $signed(cfg.coef_linear) * $signed({1'b0, dq_reg});
                state_next = FR_SUM;
            end
            FR_SUM:
            begin
                if (mm_reg <= cfg.min_depth_mm || acc <= 64'sd0)
                begin
                    pred_next = '0;
                end
                else if (rounded[47:32] != '0)
                begin
                    pred_next = SIGMA_MAX;
                end
                else
                begin
                    pred_next = rounded[31:0];
                end
                state_next = FR_PUSH;
            end
            FR_PUSH:
            begin
                q_valid = 1'b1;
                if (q_ready)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    assign q_data.flush     = flush_reg;
    assign q_data.pix.mm    = mm_reg;
    assign q_data.pix.dq    = dq_reg;
    assign q_data.pix.sigma = pred_reg;
endmodule
`default_nettype wire

@@ rtl/dswf_queue.sv @@
// Short queue between the front end and the back end.
`default_nettype none
module dswf_queue
    import dswf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire qitem_t in_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output qitem_t      out_data
);
    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    qitem_t          slot_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != CW'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end
endmodule
`default_nettype wire

@@ rtl/dswf_fuse.sv @@
// Window fusion unit: mixture moments, bit serial division and square root.
`default_nettype none
module dswf_fuse
    import dswf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire pix_t        win [9],
    input  wire logic [15:0] min_depth_mm,
    input  wire logic [31:0] sigma_floor,
    output logic             done,
    output logic [31:0]      fused
);
    fuse_state_t       state_reg, state_next;
    logic [3:0]        k_reg, k_next;
    logic              ok_reg, ok_next;
    logic [63:0]       ss_reg, ss_next;
    logic [43:0]       ddq_reg, ddq_next;
    logic [S2_W-1:0]   s2_reg, s2_next;
    logic [S1_W-1:0]   s1_reg, s1_next;
    logic [4:0]        sw_reg, sw_next;
    logic [52:0]       plo_reg, plo_next;
    logic [51:0]       phi_reg, phi_next;
    logic [NUM_W-1:0]  a_reg, a_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [63:0]       rn_reg, rn_next;
    logic [63:0]       root_reg, root_next;
    logic [63:0]       rbit_reg, rbit_next;
    logic [31:0]       res_reg, res_next;
    logic [1:0]        sh;
    logic [64:0]       term;
    logic [NUM_W-1:0]  b;
    logic [DEN_W:0]    shifted;
    logic [64:0]       rsum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FU_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        ok_reg   <= ok_next;
        ss_reg   <= ss_next;
        ddq_reg  <= ddq_next;
        s2_reg   <= s2_next;
        s1_reg   <= s1_next;
        sw_reg   <= sw_next;
        plo_reg  <= plo_next;
        phi_reg  <= phi_next;
        a_reg    <= a_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        rn_reg   <= rn_next;
        root_reg <= root_next;
        rbit_reg <= rbit_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        ok_next    = ok_reg;
        ss_next    = ss_reg;
        ddq_next   = ddq_reg;
        s2_next    = s2_reg;
        s1_next    = s1_reg;
        sw_next    = sw_reg;
        plo_next   = plo_reg;
        phi_next   = phi_reg;
        a_next     = a_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        rn_next    = rn_reg;
        root_next  = root_reg;
        rbit_next  = rbit_reg;
        res_next   = res_reg;
        sh         = win_shift(k_reg);
        term       = {1'b0, ss_reg} + {5'b0, ddq_reg, 16'b0};
        b          = NUM_W'(plo_reg) + (NUM_W'(phi_reg) << 18);
        shifted    = {rem_reg, num_reg[NUM_W-1]};
        rsum       = {1'b0, root_reg} + {1'b0, rbit_reg};
        unique case (state_reg)
            FU_IDLE:
            begin
                if (start)
                begin
                    k_next     = '0;
                    s2_next    = '0;
                    s1_next    = '0;
                    sw_next    = '0;
                    state_next = FU_MUL;
                end
            end
            FU_MUL:
            begin
                ss_next    = 64'(win[k_reg].sigma) * 64'(win[k_reg].sigma);
                ddq_next   = 44'(win[k_reg].dq) * 44'(win[k_reg].dq);
                ok_next    = (win[k_reg].mm > min_depth_mm) &&
                             (win[k_reg].sigma > sigma_floor);
                state_next = FU_ACC;
            end
            FU_ACC:
            begin
                if (ok_reg)
                begin
                    s2_next = s2_reg + (S2_W'(term) << sh);
                    s1_next = s1_reg + (S1_W'({win[k_reg].dq, 8'b0}) << sh);
                    sw_next = sw_reg + (5'd1 << sh);
                end
                k_next     = k_reg + 1'b1;
                state_next = (k_reg == 4'd8) ? FU_SQ_LO : FU_MUL;
            end
            FU_SQ_LO:
            begin
                plo_next = 53'(s1_reg) * 53'(s1_reg[17:0]);
                if (sw_reg == '0)
                begin
                    res_next   = '0;
                    state_next = FU_DONE;
                end
                else
                begin
                    state_next = FU_SQ_HI;
                end
            end
            FU_SQ_HI:
            begin
                phi_next   = 52'(s1_reg) * 52'(s1_reg[34:18]);
                a_next     = NUM_W'(s2_reg) * NUM_W'(sw_reg);
                den_next   = DEN_W'(10'(sw_reg) * 10'(sw_reg));
                state_next = FU_SUB;
            end
            FU_SUB:
            begin
                if (a_reg < b)
                begin
                    res_next   = '0;
                    state_next = FU_DONE;
                end
                else
                begin
                    num_next   = a_reg - b;
                    rem_next   = '0;
                    cnt_next   = 7'(NUM_W - 1);
                    state_next = FU_DIV;
                end
            end
            FU_DIV:
            begin
                if (shifted >= {1'b0, den_reg})
                begin
                    rem_next = DEN_W'(shifted - {1'b0, den_reg});
                    num_next = {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[DEN_W-1:0];
                    num_next = {num_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = FU_CHECK;
                end
            end
            FU_CHECK:
            begin
                if (num_reg[NUM_W-1:64] != '0)
                begin
                    res_next   = SIGMA_MAX;
                    state_next = FU_DONE;
                end
                else
                begin
                    rn_next    = num_reg[63:0];
                    root_next  = '0;
                    rbit_next  = 64'h4000_0000_0000_0000;
                    cnt_next   = 7'd31;
                    state_next = FU_ROOT;
                end
            end
            FU_ROOT:
            begin
                if ({1'b0, rn_reg} >= rsum)
                begin
                    rn_next   = rn_reg - rsum[63:0];
                    root_next = (root_reg >> 1) + rbit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                rbit_next = rbit_reg >> 2;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    res_next   = root_next[31:0];
                    state_next = FU_DONE;
                end
            end
            FU_DONE:
            begin
                state_next = FU_IDLE;
            end
            default:
            begin
                state_next = FU_IDLE;
            end
        endcase
    end

    assign done  = (state_reg == FU_DONE);
    assign fused = res_reg;
endmodule
`default_nettype wire

@@ rtl/dswf_back.sv @@
// Back end: line buffers, 3x3 window, frame bookkeeping and result register.
`default_nettype none
`include "depth_sigma_window_fusion_unit_macros.svh"
module dswf_back
    import dswf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        cfg_clear,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire qitem_t      q_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_fused,
    output logic [31:0]      out_pred,
    output logic             out_last
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int TW = WW + HW;

    back_state_t   state_reg, state_next;
    qitem_t        item_reg, item_next;
    logic [TW-1:0] pix_cnt_reg, pix_cnt_next;
    logic [TW-1:0] res_cnt_reg, res_cnt_next;
    logic [CW-1:0] col_in_reg, col_in_next;
    logic [CW-1:0] res_col_reg, res_col_next;
    logic [HW-1:0] res_row_reg, res_row_next;
    logic [TW-1:0] total_reg;
    pix_t          win_reg [9];
    pix_t          win_next [9];
    logic [31:0]   fused_reg, fused_next;
    logic [31:0]   pred_reg, pred_next;
    logic          last_reg, last_next;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_fused_reg, m_fused_next;
    logic [31:0]   m_pred_reg, m_pred_next;
    logic          m_last_reg, m_last_next;
    logic [31:0]   w_int;
    logic [31:0]   h_int;
    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [CW-1:0] raddr;
    logic          ram_we;
    logic [PIX_W-1:0] rd_a_bits;
    logic [PIX_W-1:0] rd_b_bits;
    pix_t          rd_a;
    pix_t          rd_b;
    logic          fuse_start;
    logic          fuse_done;
    logic [31:0]   fuse_result;
    logic          interior;
    logic          res_wrap;

    always_comb
    begin
        w_int = 32'(cfg.frame_width);
        h_int = 32'(cfg.frame_height);
        if (w_int < 32'd3)
        begin
            w_int = 32'd3;
        end
        else if (w_int > 32'(MAX_WIDTH))
        begin
            w_int = 32'(MAX_WIDTH);
        end
        if (h_int < 32'd3)
        begin
            h_int = 32'd3;
        end
        else if (h_int > 32'(MAX_HEIGHT))
        begin
            h_int = 32'(MAX_HEIGHT);
        end
        w = w_int[WW-1:0];
        h = h_int[HW-1:0];
    end

    assign raddr = item_reg.flush ? res_col_reg : col_in_reg;
    assign rd_a  = pix_t'(rd_a_bits);
    assign rd_b  = pix_t'(rd_b_bits);

    dswf_ram #(.W(PIX_W), .D(MAX_WIDTH)) u_row_old (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_in_reg),
        .wdata (rd_b_bits),
        .raddr (raddr),
        .rdata (rd_a_bits)
    );

    dswf_ram #(.W(PIX_W), .D(MAX_WIDTH)) u_row_new (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_in_reg),
        .wdata (PIX_W'(item_reg.pix)),
        .raddr (raddr),
        .rdata (rd_b_bits)
    );

    dswf_fuse u_fuse (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (fuse_start),
        .win          (win_reg),
        .min_depth_mm (cfg.min_depth_mm),
        .sigma_floor  (cfg.sigma_floor),
        .done         (fuse_done),
        .fused        (fuse_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            pix_cnt_reg <= '0;
            res_cnt_reg <= '0;
            col_in_reg  <= '0;
            res_col_reg <= '0;
            res_row_reg <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            pix_cnt_reg <= pix_cnt_next;
            res_cnt_reg <= res_cnt_next;
            col_in_reg  <= col_in_next;
            res_col_reg <= res_col_next;
            res_row_reg <= res_row_next;
            total_reg   <= TW'(w) * TW'(h);
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        fused_reg   <= fused_next;
        pred_reg    <= pred_next;
        last_reg    <= last_next;
        m_fused_reg <= m_fused_next;
        m_pred_reg  <= m_pred_next;
        m_last_reg  <= m_last_next;
    end

    assign interior = (res_row_reg != '0) && ((12'(res_row_reg) + 12'd2) <= 12'(h)) &&
                      (res_col_reg != '0) && ((WW'(res_col_reg) + WW'(2)) <= w);
    assign res_wrap = ((WW'(res_col_reg) + WW'(1)) == w);

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        pix_cnt_next = pix_cnt_reg;
        res_cnt_next = res_cnt_reg;
        col_in_next  = col_in_reg;
        res_col_next = res_col_reg;
        res_row_next = res_row_reg;
        fused_next   = fused_reg;
        pred_next    = pred_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        m_fused_next = m_fused_reg;
        m_pred_next  = m_pred_reg;
        m_last_next  = m_last_reg;
        for (int i = 0; i < 9; i++)
        begin
            win_next[i] = win_reg[i];
        end
        q_ready    = 1'b0;
        ram_we     = 1'b0;
        fuse_start = 1'b0;
        if (out_ready)
        begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            B_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    item_next = q_data;
                    if (q_data.flush)
                    begin
                        if (pix_cnt_reg >= total_reg && res_cnt_reg < total_reg)
                        begin
                            state_next = B_READ;
                        end
                    end
                    else if (pix_cnt_reg < total_reg)
                    begin
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_APPLY;
            end
            B_APPLY:
            begin
                last_next = ((res_cnt_reg + 1'b1) == total_reg);
                if (item_reg.flush)
                begin
                    pred_next  = ((12'(res_row_reg) + 12'd1) == 12'(h)) ? rd_b.sigma
                                                                      : rd_a.sigma;
                    fused_next = pred_next;
                    if ((res_cnt_reg + 1'b1) >= total_reg)
                    begin
                        pix_cnt_next = '0;
                        res_cnt_next = '0;
                        col_in_next  = '0;
                        res_col_next = '0;
                        res_row_next = '0;
                    end
                    else
                    begin
                        res_cnt_next = res_cnt_reg + 1'b1;
                        res_col_next = res_wrap ? '0 : res_col_reg + 1'b1;
                        res_row_next = res_wrap ? res_row_reg + 1'b1 : res_row_reg;
                    end
                    state_next = B_OUT;
                end
                else
                begin
                    ram_we = 1'b1;
                    for (int r = 0; r < 3; r++)
                    begin
                        win_next[r * 3]     = win_reg[r * 3 + 1];
                        win_next[r * 3 + 1] = win_reg[r * 3 + 2];
                    end
                    win_next[2]  = rd_a;
                    win_next[5]  = rd_b;
                    win_next[8]  = item_reg.pix;
                    pix_cnt_next = pix_cnt_reg + 1'b1;
                    col_in_next  = ((WW'(col_in_reg) + WW'(1)) == w) ? '0
                                                                     : col_in_reg + 1'b1;
                    if (pix_cnt_reg < (TW'(w) + 1'b1))
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        pred_next    = win_next[4].sigma;
                        fused_next   = pred_next;
                        res_cnt_next = res_cnt_reg + 1'b1;
                        res_col_next = res_wrap ? '0 : res_col_reg + 1'b1;
                        res_row_next = res_wrap ? res_row_reg + 1'b1 : res_row_reg;
                        state_next   = interior ? B_FSTART : B_OUT;
                    end
                end
            end
            B_FSTART:
            begin
                fuse_start = 1'b1;
                state_next = B_FUSE;
            end
            B_FUSE:
            begin
                if (fuse_done)
                begin
                    fused_next = fuse_result;
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!m_valid_reg || out_ready)
                begin
                    m_valid_next = 1'b1;
                    m_fused_next = fused_reg;
                    m_pred_next  = pred_reg;
                    m_last_next  = last_reg;
                    state_next   = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        if (cfg_clear)
        begin
            pix_cnt_next = '0;
            res_cnt_next = '0;
            col_in_next  = '0;
            res_col_next = '0;
            res_row_next = '0;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_fused = m_fused_reg;
    assign out_pred  = m_pred_reg;
    assign out_last  = m_last_reg;

    `DSWF_CHECK(a_results_behind_pixels, res_cnt_reg <= pix_cnt_reg,
        "More results given than pixels taken.")
    `DSWF_CHECK(a_column_in_row, WW'(col_in_reg) < w,
        "Input column ran past the frame width.")
    `DSWF_IMPLIES(a_fuse_done_when_waiting, fuse_done, state_reg == B_FUSE,
        "Fusion unit finished while the back end was not waiting for it.")
endmodule
`default_nettype wire

@@ rtl/depth_sigma_window_fusion_unit.sv @@
// Top level of the depth sigma window fusion unit.
// The front end takes one pixel at a time (accept, depth conversion, sigma
// prediction and queue push) and accepts the next only after the push. A pixel
// whose 3x3 window is fused passes through nine moment steps, a bit serial
// division and a square root in the fusion unit, with the front end's depth
// conversion and sigma prediction overlapped through a two entry queue. Results
// lag the pixel stream by frame width plus one pixels; after the last pixel of a
// frame, one flush transfer drains each pending result, and the result of the
// frame's final pixel carries tlast. Writing the frame width or height restarts
// the frame.
`default_nettype none
module depth_sigma_window_fusion_unit
    import dswf_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // depth_mm
    input  wire logic        s_tuser,    // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,    // predicted_sigma (high), fused_sigma (low)
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    cfg_t        cfg_reg;
    logic        cfg_clear;
    logic        q_in_valid;
    logic        q_in_ready;
    qitem_t      q_in_data;
    logic        q_out_valid;
    logic        q_out_ready;
    qitem_t      q_out_data;
    logic [31:0] fused;
    logic [31:0] pred;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= RST_FRAME_WIDTH;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
            cfg_reg.coef_square  <= RST_COEF_SQUARE;
            cfg_reg.coef_linear  <= RST_COEF_LINEAR;
            cfg_reg.coef_const   <= RST_COEF_CONST;
            cfg_reg.min_depth_mm <= RST_MIN_DEPTH;
            cfg_reg.sigma_floor  <= RST_SIGMA_FLOOR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[10:0];
                CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[10:0];
                CFG_COEF_SQUARE:  cfg_reg.coef_square  <= cfg_data;
                CFG_COEF_LINEAR:  cfg_reg.coef_linear  <= cfg_data;
                CFG_COEF_CONST:   cfg_reg.coef_const   <= cfg_data;
                CFG_MIN_DEPTH:    cfg_reg.min_depth_mm <= cfg_data[15:0];
                CFG_SIGMA_FLOOR:  cfg_reg.sigma_floor  <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg_clear = cfg_we && (cfg_index == CFG_FRAME_WIDTH ||
                                  cfg_index == CFG_FRAME_HEIGHT);

    dswf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_depth_mm (s_tdata),
        .q_valid     (q_in_valid),
        .q_ready     (q_in_ready),
        .q_data      (q_in_data)
    );

    dswf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    dswf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_clear (cfg_clear),
        .q_valid   (q_out_valid),
        .q_ready   (q_out_ready),
        .q_data    (q_out_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_fused (fused),
        .out_pred  (pred),
        .out_last  (m_tlast)
    );

    assign m_tdata = {pred, fused};
endmodule
`default_nettype wire
